// File: hw/rtl/tclr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclr_pkg: shared definitions of the text console line ring
// Default geometry, character codes, opcodes, control states and the
// result beat carried from the read pipeline to the output queue.
// ----------------------------------------------------------------------------
package tclr_pkg;

   // Default geometry of the ring (top level parameters take these)
   localparam int RING_LINES_DEF = 64;
   localparam int LINE_WIDTH_DEF = 80;

   // Window height and the colour a line holds until first written
   localparam int         SHOWN_LINES = 32;
   localparam logic [7:0] BLANK_COLOR = 8'd7;

   // Character codes with a meaning of their own
   localparam logic [7:0] KEY_BACKSPACE = 8'h08;
   localparam logic [7:0] KEY_NEWLINE   = 8'h0a;

   // Output queue geometry
   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 2;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_PUT2
   } state_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic [7:0] read_color;
      logic       line_visible;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
   } result_type;

endpackage

// File: hw/rtl/tclr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclr_ram: generic synchronous RAM
// One write port and one read port; read data is registered, so it shows
// in the cycle after the address. A read and a write of one entry in the same
// cycle return the old contents.
// ----------------------------------------------------------------------------
module tclr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tclr_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclr_rsp_fifo: result beat queue
// Small register queue between the read pipeline and the result channel.
// The writer checks the fill count and never pushes into a full queue.
// ----------------------------------------------------------------------------
module tclr_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push_valid,
   input  tclr_pkg::result_type             push_data,
   output logic                             out_valid,
   input  logic                             out_stall,
   output tclr_pkg::result_type             out_data,
   output logic [tclr_pkg::RSP_CNT_W-1:0]   count
);

   localparam logic [tclr_pkg::RSP_PTR_W-1:0] LAST_PTR =
      tclr_pkg::RSP_PTR_W'(tclr_pkg::RSP_DEPTH - 1);

   tclr_pkg::result_type                entry_ff [tclr_pkg::RSP_DEPTH];
   logic [tclr_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tclr_pkg::RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tclr_pkg::RSP_CNT_W-1:0]      count_ff, count_in;
   logic                                pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/text_console_line_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_line_ring: text console line store kept as a ring of lines
// Character cells live in one RAM, line colours in a second; a small FSM
// drives the write port and a read pipeline feeds a result queue.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall): one beat is either a put of a
//   character (backspace, newline or any other byte) with the line
//   colour, or a read of a displayed row and column.
//   rsp channel (rsp_valid / rsp_stall): exactly one beat per request, in
//   order: the cell and colour for a read (zeros for a put) plus the
//   cursor position after the request.
//   Order: a taken request is registered in the read stage, then written
//   into the result queue, from which it is offered. A put of any byte
//   but backspace or newline holds off the next request for the write of
//   the following blank cell, since both writes share the one RAM write port.
//   Reset: the whole cell RAM, RING_LINES*(LINE_WIDTH+2) entries (5248 at
//   the defaults), is swept to zero and every line colour set to the
//   blank colour, one entry per cycle; req_stall stays high meanwhile.
//   Stall: results pile up in a three-beat queue; requests keep flowing
//   until the queue plus the beat in flight would overflow it.
// ----------------------------------------------------------------------------
module text_console_line_ring #(
   parameter int RING_LINES = tclr_pkg::RING_LINES_DEF,
   parameter int LINE_WIDTH = tclr_pkg::LINE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_color,
   input  logic [4:0] req_row,
   input  logic [6:0] req_col,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_char,
   output logic [7:0] rsp_read_color,
   output logic       rsp_line_visible,
   output logic [4:0] rsp_cursor_row,
   output logic [6:0] rsp_cursor_col
);

   // Geometry: each line holds LINE_WIDTH+1 characters plus one spare cell
   localparam int CELLS = LINE_WIDTH + 2;
   localparam int DEPTH = RING_LINES * CELLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(RING_LINES);
   localparam int NCW   = $clog2(LINE_WIDTH + 1);
   localparam int SW    = ((LW > 5) ? LW : 5) + 1;

   localparam logic [LW-1:0]  LAST_LINE = LW'(RING_LINES - 1);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0]  CELLS_A   = AW'(CELLS);
   localparam logic [NCW-1:0] LAST_COL  = NCW'(LINE_WIDTH);
   localparam logic [SW-1:0]  RING_S    = SW'(RING_LINES);
   localparam logic [LW:0]    RING_D    = (LW + 1)'(RING_LINES);
   localparam logic [4:0]     SHOWN_ROW = 5'((tclr_pkg::SHOWN_LINES - 1) % 32);

   // --------------------------------------------------------------------
   // State
   // --------------------------------------------------------------------
   tclr_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [LW-1:0]       cur_ff, cur_in;        // ring line of the cursor
   logic [AW-1:0]       cur_base_ff, cur_base_in;
   logic [LW-1:0]       top_ff, top_in;        // ring line shown at row 0
   logic [NCW-1:0]      nc_ff, nc_in;          // next column in cursor line
   logic [AW-1:0]       p2_addr_ff, p2_addr_in;
   logic                need_p2;

   // read pipeline stage
   logic                s1_valid_ff;
   logic                s1_vis_ff, s1_vis_in;
   logic                s1_col_ok_ff, s1_col_ok_in;
   logic [4:0]          s1_crow_ff, s1_crow_in;
   logic [6:0]          s1_ccol_ff, s1_ccol_in;

   // RAM ports
   logic                char_we;
   logic [AW-1:0]       char_waddr;
   logic [7:0]          char_wdata;
   logic [AW-1:0]       char_raddr;
   logic [7:0]          char_q;
   logic                color_we;
   logic [LW-1:0]       color_waddr;
   logic [7:0]          color_wdata;
   logic [LW-1:0]       color_raddr;
   logic [7:0]          color_q;

   // handshake and queue
   logic                              accept;
   logic                              is_put;
   logic                              is_read;
   logic                              queue_full;
   logic [tclr_pkg::RSP_CNT_W-1:0]    q_count;
   tclr_pkg::result_type              push_data;
   tclr_pkg::result_type              out_data;

   // line advance helpers
   logic [LW-1:0]       cur_nx;
   logic [AW-1:0]       base_nx;
   logic [LW-1:0]       top_nx;
   logic [LW:0]         span;
   logic                top_adv;

   assign accept  = req_valid && !req_stall;
   assign is_put  = accept && (req_opcode == tclr_pkg::OP_PUT);
   assign is_read = accept && (req_opcode == tclr_pkg::OP_READ);

   // --------------------------------------------------------------------
   // Next line of the ring and whether the window must scroll with it
   // --------------------------------------------------------------------
   always_comb begin
      cur_nx  = (cur_ff == LAST_LINE) ? '0 : cur_ff + 1'b1;
      base_nx = (cur_ff == LAST_LINE) ? '0 : cur_base_ff + CELLS_A;
      top_nx  = (top_ff == LAST_LINE) ? '0 : top_ff + 1'b1;
      if (cur_nx >= top_ff) begin
         span = {1'b0, cur_nx} - {1'b0, top_ff};
      end else begin
         span = {1'b0, cur_nx} + RING_D - {1'b0, top_ff};
      end
      // scroll once the new line would fall below the window
      top_adv = (32'(span) > 32'(tclr_pkg::SHOWN_LINES - 1));
   end

   // --------------------------------------------------------------------
   // Write port and cursor update
   // --------------------------------------------------------------------
   always_comb begin
      cur_in      = cur_ff;
      cur_base_in = cur_base_ff;
      top_in      = top_ff;
      nc_in       = nc_ff;
      p2_addr_in  = p2_addr_ff;
      need_p2     = 1'b0;
      clr_addr_in = clr_addr_ff;
      char_we     = 1'b0;
      char_waddr  = clr_addr_ff;
      char_wdata  = '0;
      color_we    = 1'b0;
      color_waddr = clr_addr_ff[LW-1:0];
      color_wdata = tclr_pkg::BLANK_COLOR;

      case (state_ff)
         tclr_pkg::ST_CLEAR: begin
            // sweep the cell RAM; the first RING_LINES steps also reset colours
            char_we     = 1'b1;
            color_we    = (32'(clr_addr_ff) < 32'(RING_LINES));
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         tclr_pkg::ST_PUT2: begin
            // blank the cell after the character just written
            char_we    = 1'b1;
            char_waddr = p2_addr_ff;
         end
         tclr_pkg::ST_RUN: begin
            if (is_put) begin
               case (req_char_code)
                  tclr_pkg::KEY_BACKSPACE: begin
                     // drop the previous cell; nothing to do at column zero
                     if (nc_ff != '0) begin
                        nc_in      = nc_ff - 1'b1;
                        char_we    = 1'b1;
                        char_waddr = cur_base_ff + AW'(nc_ff) - 1'b1;
                     end
                  end
                  tclr_pkg::KEY_NEWLINE: begin
                     color_we    = 1'b1;
                     color_waddr = cur_ff;
                     color_wdata = req_color;
                     cur_in      = cur_nx;
                     cur_base_in = base_nx;
                     top_in      = top_adv ? top_nx : top_ff;
                     nc_in       = '0;
                     char_we     = 1'b1;
                     char_waddr  = base_nx;
                  end
                  default: begin
                     color_we    = 1'b1;
                     color_waddr = cur_ff;
                     color_wdata = req_color;
                     char_we     = 1'b1;
                     char_waddr  = cur_base_ff + AW'(nc_ff);
                     char_wdata  = req_char_code;
                     need_p2     = 1'b1;
                     if (nc_ff == LAST_COL) begin
                        // line full: wrap; the last spare cell is always blank
                        cur_in      = cur_nx;
                        cur_base_in = base_nx;
                        top_in      = top_adv ? top_nx : top_ff;
                        nc_in       = '0;
                        p2_addr_in  = base_nx;
                     end else begin
                        nc_in      = nc_ff + 1'b1;
                        p2_addr_in = cur_base_ff + AW'(nc_ff) + 1'b1;
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------------------
   // Read address and visibility of the requested row
   // --------------------------------------------------------------------
   always_comb begin
      logic [4:0]      row_red;
      logic [SW-1:0]   idx_sum;
      logic [LW-1:0]   idx;
      logic            row_ok;
      logic            hidden;
      logic [LW+4:0]   cur_wide;
      logic [NCW+6:0]  nc_wide;

      // reduce the row modulo the ring size, one binary step at a time
      row_red = req_row;
      for (int k = 4; k >= 0; k--) begin
         if (32'(row_red) >= (32'(RING_LINES) << k)) begin
            row_red = row_red - 5'(RING_LINES << k);
         end
      end
      idx_sum = SW'(top_ff) + SW'(row_red);
      if (idx_sum >= RING_S) begin
         idx_sum = idx_sum - RING_S;
      end
      idx = idx_sum[LW-1:0];

      row_ok = (32'(req_row) < 32'(tclr_pkg::SHOWN_LINES));
      if (top_ff <= cur_ff) begin
         hidden = (cur_ff < idx);
      end else begin
         hidden = (cur_ff < idx) && (idx < top_ff);
      end

      s1_vis_in    = is_read && row_ok && !hidden;
      s1_col_ok_in = (32'(req_col) < 32'(CELLS));
      color_raddr  = idx;
      char_raddr   = AW'(idx) * CELLS_A + AW'(req_col);

      // cursor after this request
      cur_wide   = {5'b0, cur_in};
      nc_wide    = {7'b0, nc_in};
      s1_crow_in = (top_in == '0) ? cur_wide[4:0] : SHOWN_ROW;
      s1_ccol_in = nc_wide[6:0];
   end

   // --------------------------------------------------------------------
   // Control FSM
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tclr_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = tclr_pkg::ST_RUN;
            end
         end
         tclr_pkg::ST_RUN: begin
            if (need_p2) begin
               state_in = tclr_pkg::ST_PUT2;
            end
         end
         tclr_pkg::ST_PUT2: begin
            state_in = tclr_pkg::ST_RUN;
         end
         default: begin
            state_in = tclr_pkg::ST_CLEAR;
         end
      endcase
   end

   // hold requests while clearing, during the second write of a put, and
   // while the queue has no room for one more beat beyond those in flight
   assign queue_full = (3'(q_count) + 3'(s1_valid_ff)) >= 3'(tclr_pkg::RSP_DEPTH);

   always_comb begin
      case (state_ff)
         tclr_pkg::ST_RUN: req_stall = queue_full;
         default:          req_stall = 1'b1;
      endcase
   end

   // --------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tclr_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         cur_ff      <= '0;
         cur_base_ff <= '0;
         top_ff      <= '0;
         nc_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cur_ff      <= cur_in;
         cur_base_ff <= cur_base_in;
         top_ff      <= top_in;
         nc_ff       <= nc_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      p2_addr_ff   <= p2_addr_in;
      s1_vis_ff    <= s1_vis_in;
      s1_col_ok_ff <= s1_col_ok_in;
      s1_crow_ff   <= s1_crow_in;
      s1_ccol_ff   <= s1_ccol_in;
   end

   // --------------------------------------------------------------------
   // Memories
   // --------------------------------------------------------------------
   tclr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (char_waddr),
      .wr_data (char_wdata),
      .rd_en   (is_read),
      .rd_addr (char_raddr),
      .rd_data (char_q)
   );

   tclr_ram #(
      .WIDTH (8),
      .DEPTH (RING_LINES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_we),
      .wr_addr (color_waddr),
      .wr_data (color_wdata),
      .rd_en   (is_read),
      .rd_addr (color_raddr),
      .rd_data (color_q)
   );

   // --------------------------------------------------------------------
   // Result assembly and output queue
   // --------------------------------------------------------------------
   always_comb begin
      push_data.read_char    = (s1_vis_ff && s1_col_ok_ff) ? char_q : 8'd0;
      push_data.read_color   = s1_vis_ff ? color_q : 8'd0;
      push_data.line_visible = s1_vis_ff;
      push_data.cursor_row   = s1_crow_ff;
      push_data.cursor_col   = s1_ccol_ff;
   end

   tclr_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (push_data),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (out_data),
      .count      (q_count)
   );

   assign rsp_read_char    = out_data.read_char;
   assign rsp_read_color   = out_data.read_color;
   assign rsp_line_visible = out_data.line_visible;
   assign rsp_cursor_row   = out_data.cursor_row;
   assign rsp_cursor_col   = out_data.cursor_col;

endmodule

// File: bench/tb_text_console_line_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_line_ring: self-checking bench of the console line ring
// Put and read beats are queued by the stimulus block and driven by a
// clocked driver. A scoreboard model of the ring predicts every result
// beat. A monitor checks each result, field by field, in order. Phases
// vary sender gaps and receiver stalls, and a watchdog catches a hang.
// ----------------------------------------------------------------------------
module tb_text_console_line_ring;
   import tclr_pkg::*;

   localparam int RING    = RING_LINES_DEF;
   localparam int WIDTH   = LINE_WIDTH_DEF;
   localparam int CELLS   = WIDTH + 2;
   localparam int LAST_COL = CELLS - 1;

   // The limit outlasts the reset sweep of all RING*CELLS cells, with no beat moving
   localparam int WATCHDOG_LIMIT = 30000;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_ITEMS    = 132;

   typedef struct {
      opcode_type opcode;
      logic [7:0] char_code;
      logic [7:0] color;
      logic [4:0] row;
      logic [6:0] col;
   } console_request;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_opcode = 1'b0;
   logic [7:0] req_char_code = 8'h00;
   logic [7:0] req_color = 8'h00;
   logic [4:0] req_row = 5'd0;
   logic [6:0] req_col = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_char;
   logic [7:0] rsp_read_color;
   logic       rsp_line_visible;
   logic [4:0] rsp_cursor_row;
   logic [6:0] rsp_cursor_col;

   // Beats waiting to be offered, and results the ring owes us
   console_request pending_requests[$];
   result_type     owed_results[$];
   console_request offered_request;
   console_request queued_request;

   // Scoreboard copy of the ring contents and cursor
   logic [7:0]  shadow_cells [0:RING*CELLS-1];
   logic [7:0]  shadow_colors [0:RING-1];
   int unsigned cur_line = 0;
   int unsigned top_line = 0;
   int unsigned next_col = 0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int holdoff_asked = 0;
   int holdoff_served = 0;
   int holdoff_left = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   text_console_line_ring DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_char_code    (req_char_code),
      .req_color        (req_color),
      .req_row          (req_row),
      .req_col          (req_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_char    (rsp_read_char),
      .rsp_read_color   (rsp_read_color),
      .rsp_line_visible (rsp_line_visible),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Scoreboard model
   // ------------------------------------------------------------------

   // Advance to the next ring line, scroll once the window is full, and
   // blank the first cell of the fresh line.
   function automatic void open_next_line();
      int unsigned span;
      next_col = 0;
      cur_line = (cur_line + 1) % RING;
      span = cur_line;
      if (span < top_line) begin
         span += RING;
      end
      if (span - top_line > SHOWN_LINES - 1) begin
         top_line = (top_line + 1) % RING;
      end
      shadow_cells[cur_line*CELLS] = 8'h00;
   endfunction

   // Apply one beat to the model and return the result it owes.
   function automatic result_type console_step(console_request r);
      result_type  res;
      int unsigned base;
      int unsigned idx;
      bit          hidden;
      res = '0;
      base = cur_line * CELLS;
      if (r.opcode == OP_PUT) begin
         if (r.char_code == KEY_BACKSPACE) begin
            // Backspace at column zero leaves everything alone
            if (next_col > 0) begin
               next_col--;
               shadow_cells[base+next_col] = 8'h00;
            end
         end else if (r.char_code == KEY_NEWLINE) begin
            shadow_colors[cur_line] = r.color;
            open_next_line();
         end else begin
            shadow_colors[cur_line] = r.color;
            if (next_col < CELLS) begin
               shadow_cells[base+next_col] = r.char_code;
            end
            next_col++;
            if (next_col < CELLS) begin
               shadow_cells[base+next_col] = 8'h00;
            end
            // Wrap a line that grew past its width
            if (next_col > WIDTH) begin
               open_next_line();
            end
         end
      end else if (int'(r.row) < SHOWN_LINES) begin
         idx = (top_line + r.row) % RING;
         if (top_line <= cur_line) begin
            hidden = cur_line < idx;
         end else begin
            hidden = (cur_line < idx) && (idx < top_line);
         end
         if (!hidden) begin
            res.line_visible = 1'b1;
            res.read_color = shadow_colors[idx];
            if (r.col < CELLS) begin
               res.read_char = shadow_cells[idx*CELLS+r.col];
            end
         end
      end
      res.cursor_row = (top_line == 0) ? cur_line[4:0] : 5'(SHOWN_LINES - 1);
      res.cursor_col = next_col[6:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Fill the fields a put ignores with noise so every bit toggles.
   function automatic console_request make_put(logic [7:0] ch, logic [7:0] colr);
      console_request r;
      r.opcode = OP_PUT;
      r.char_code = ch;
      r.color = colr;
      r.row = 5'($urandom_range(0, 31));
      r.col = 7'($urandom_range(0, LAST_COL));
      return r;
   endfunction

   function automatic console_request make_read(int rw, int cl);
      console_request r;
      r.opcode = OP_READ;
      r.char_code = 8'($urandom_range(0, 255));
      r.color = 8'($urandom_range(0, 255));
      r.row = 5'(rw);
      r.col = 7'(cl);
      return r;
   endfunction

   // Queue a random mix of puts and reads. Newlines come often enough to
   // scroll the window and wrap the ring; now and then a full line of
   // text forces a wrap by width.
   task automatic add_random_items(int count);
      int left;
      int pick;
      int burst;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            burst = (left < CELLS) ? left : WIDTH + 1;
            repeat (burst) begin
               pending_requests.push_back(make_put(8'($urandom_range(32, 126)),
                                                   8'($urandom_range(0, 255))));
            end
            left -= burst;
         end else if (pick < 57) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
               pending_requests.push_back(make_put(KEY_NEWLINE, 8'($urandom_range(0, 255))));
            end else if (pick < 34) begin
               pending_requests.push_back(make_put(KEY_BACKSPACE, 8'($urandom_range(0, 255))));
            end else begin
               pending_requests.push_back(make_put(8'($urandom_range(0, 255)),
                                                   8'($urandom_range(0, 255))));
            end
            left--;
         end else begin
            // Bias reads toward the columns that usually hold text
            if ($urandom_range(0, 1) == 0) begin
               pending_requests.push_back(make_read($urandom_range(0, 31),
                                                    $urandom_range(0, 15)));
            end else begin
               pending_requests.push_back(make_read($urandom_range(0, 31),
                                                    $urandom_range(0, LAST_COL)));
            end
            left--;
         end
      end
   endtask

   function automatic bit console_drained();
      return pending_requests.size() == 0 && !req_valid && owed_results.size() == 0;
   endfunction

   task automatic wait_drained();
      while (!console_drained()) begin
         @(negedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: offer queued beats, hold a stalled beat, gap at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Predict the beat that moves on this edge
         if (req_valid && !req_stall) begin
            owed_results.push_back(console_step(offered_request));
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               queued_request = pending_requests.pop_front();
               offered_request = queued_request;
               req_valid     <= 1'b1;
               req_opcode    <= queued_request.opcode;
               req_char_code <= queued_request.char_code;
               req_color     <= queued_request.color;
               req_row       <= queued_request.row;
               req_col       <= queued_request.col;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result beat, drive rsp_stall
   // ------------------------------------------------------------------
   task automatic report_mismatch(string field, int unsigned want, int unsigned got);
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $display("%0t ns: result beat with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_read_char !== want.read_char)
                  report_mismatch("read_char", want.read_char, rsp_read_char);
               if (rsp_read_color !== want.read_color)
                  report_mismatch("read_color", want.read_color, rsp_read_color);
               if (rsp_line_visible !== want.line_visible)
                  report_mismatch("line_visible", want.line_visible, rsp_line_visible);
               if (rsp_cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", want.cursor_row, rsp_cursor_row);
               if (rsp_cursor_col !== want.cursor_col)
                  report_mismatch("cursor_col", want.cursor_col, rsp_cursor_col);
            end
         end
         // A requested hold-off keeps stall high for a long stretch so the
         // result queue fills and the ring stalls its input
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
         end else if (holdoff_served != holdoff_asked) begin
            rsp_stall <= 1'b1;
            holdoff_served <= holdoff_served + 1;
            holdoff_left <= HOLDOFF_CYCLES;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count edges at which no beat moves on either channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and phase control
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < RING*CELLS; i++) begin
         shadow_cells[i] = 8'h00;
      end
      for (int i = 0; i < RING; i++) begin
         shadow_colors[i] = BLANK_COLOR;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: fresh screen, backspace at column zero, field
      // extremes, backspace keeping the colour, newline, hidden rows
      pending_requests.push_back(make_read(0, 0));
      pending_requests.push_back(make_read(31, LAST_COL));
      pending_requests.push_back(make_put(KEY_BACKSPACE, 8'hff));
      pending_requests.push_back(make_read(0, 0));
      pending_requests.push_back(make_put(8'h41, 8'hff));
      pending_requests.push_back(make_put(8'hff, 8'h00));
      pending_requests.push_back(make_put(8'h00, 8'haa));
      pending_requests.push_back(make_put(8'h7f, 8'h55));
      pending_requests.push_back(make_put(KEY_BACKSPACE, 8'h12));
      pending_requests.push_back(make_read(0, 0));
      pending_requests.push_back(make_read(0, 1));
      pending_requests.push_back(make_read(0, 3));
      pending_requests.push_back(make_read(0, LAST_COL));
      pending_requests.push_back(make_put(KEY_NEWLINE, 8'h3c));
      pending_requests.push_back(make_read(0, 0));
      pending_requests.push_back(make_read(1, 0));
      pending_requests.push_back(make_read(2, 0));
      pending_requests.push_back(make_put(8'h80, 8'h80));
      pending_requests.push_back(make_put(KEY_NEWLINE, 8'h01));
      pending_requests.push_back(make_put(KEY_BACKSPACE, 8'hfe));
      pending_requests.push_back(make_read(16, 64));
      pending_requests.push_back(make_read(1, 0));
      wait_drained();

      // No idling; one long receiver hold-off while the sender keeps on
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      add_random_items(PHASE_ITEMS);
      holdoff_asked = 1;
      wait_drained();

      // Sender gaps most cycles
      sender_idle_pct = 72;
      receiver_stall_pct = 0;
      add_random_items(PHASE_ITEMS);
      wait_drained();

      // Receiver stalls most cycles
      sender_idle_pct = 0;
      receiver_stall_pct = 72;
      add_random_items(PHASE_ITEMS);
      wait_drained();

      // Light idling on both sides
      sender_idle_pct = 16;
      receiver_stall_pct = 16;
      add_random_items(PHASE_ITEMS);
      wait_drained();

      // Let any stray beat surface before the verdict
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
